/* src/efla_pkg.sv */
package efla_pkg;

    localparam int WORD_W       = 32;
    localparam int REQ_W        = 21;
    localparam int BADDR_W      = 20;
    localparam int THR_W        = 21;
    localparam int NEED_W       = 22;
    localparam int THR_RESET    = 100;
    localparam int MIN_BLOCK    = 16;
    localparam int SPLIT_SLACK  = 16;
    localparam int SMALL_REQ    = 8;
    localparam int PROLOGUE_TAG = 9;
    localparam int FIRST_BLOCK  = 16;
    localparam int EPILOGUE_TAG = 1;

    typedef enum logic
    {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } action_t;

    typedef struct packed
    {
        logic              rd;
        logic              wr;
        logic [WORD_W-1:0] addr;
        logic [WORD_W-1:0] wdata;
    } mem_req_t;

    typedef enum logic [6:0]
    {
        ST_CLEAR, ST_IDLE,
        ST_S1, ST_S2, ST_S3,
        ST_GROW, ST_G1, ST_G2, ST_G3, ST_GROW_RET,
        ST_C1, ST_C2,
        ST_K0, ST_K1, ST_K2, ST_K3, ST_K4, ST_K5, ST_K6,
        ST_FIN0, ST_FIN1,
        ST_F1, ST_F2, ST_F3, ST_FREE_DONE,
        ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5,
        ST_M20, ST_M21, ST_M22, ST_M23, ST_M24,
        ST_M30, ST_M31, ST_M32, ST_M33, ST_M34, ST_M35, ST_M36, ST_M37, ST_M38,
        ST_M40, ST_M41, ST_M42, ST_M43, ST_M44, ST_M45, ST_M46, ST_M47, ST_M48,
        ST_M49, ST_M4A, ST_M4B, ST_M4C, ST_M4D,
        ST_CHK0, ST_CHK1, ST_MRET,
        ST_U0, ST_U1, ST_U2, ST_U3, ST_U4,
        ST_L0, ST_L1, ST_L2, ST_L3, ST_L4, ST_L5, ST_L6, ST_L7
    } state_t;

endpackage

/* src/explicit_free_list_heap_allocator.sv */
// a zero allocate or a bad free is answered from idle; an allocate walks the free list and
// grows the heap when the walk finds no fit; a free coalesces the block with its free
// neighbours
// throughput: one request at a time, every heap word access goes through the single
// read/write port of the heap memory with a registered read
// reset: a clearing pass writes the initial heap image into all HEAP_BYTES/4 words
// (262144 by default) with busy high; results cannot be stalled by the receiver
module explicit_free_list_heap_allocator
    import efla_pkg::*;
#(
    parameter int HEAP_BYTES  = 1048576,
    parameter int CHUNK_BYTES = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               action,
    input  logic [REQ_W-1:0]   request_bytes,
    input  logic [BADDR_W-1:0] block_address,
    input  logic               cfg_write,
    input  logic [THR_W-1:0]   cfg_data,
    output logic               done,
    output logic [BADDR_W-1:0] payload_address,
    output logic               granted
);

    localparam int MAX_WALK  = HEAP_BYTES / 16 + 1;
    localparam int WALK_W    = $clog2(MAX_WALK);
    localparam int CHUNK_SZ  = ((CHUNK_BYTES / 4 + 1) / 2) * 8;
    localparam bit INIT_FITS = (CHUNK_SZ <= HEAP_BYTES - 32);
    localparam int INIT_BRK  = INIT_FITS ? 32 + CHUNK_SZ : 32;

    state_t              state_reg, state_next;
    state_t              sub_ret_reg, sub_ret_next;
    state_t              merge_ret_reg, merge_ret_next;
    logic [WORD_W-1:0]   brk_reg, brk_next;
    logic [WORD_W-1:0]   head_reg, head_next;
    logic [WORD_W-1:0]   rover_reg, rover_next;
    logic [THR_W-1:0]    thr_reg;
    logic [WORD_W-1:0]   p_reg, p_next;
    logic [WORD_W-1:0]   a_reg, a_next;
    logic [WORD_W-1:0]   x_reg, x_next;
    logic [WORD_W-1:0]   sz_reg, sz_next;
    logic [WORD_W-1:0]   stop_reg, stop_next;
    logic [WORD_W-1:0]   succ_reg, succ_next;
    logic [WORD_W-1:0]   pred_reg, pred_next;
    logic [WORD_W-1:0]   v1_reg, v1_next;
    logic [WORD_W-1:0]   v2_reg, v2_next;
    logic [NEED_W-1:0]   need_reg, need_next;
    logic [WALK_W-1:0]   cnt_reg, cnt_next;
    logic                prev_used_reg, prev_used_next;
    logic                nosplit_reg, nosplit_next;
    logic                hi_reg, hi_next;
    logic                done_reg;
    logic [BADDR_W-1:0]  paddr_reg;
    logic                granted_reg;

    mem_req_t            mreq;
    logic [WORD_W-1:0]   rv;
    logic                mem_ready;
    logic [WORD_W-1:0]   rv_size;
    logic [WORD_W-1:0]   need32;
    logic [NEED_W-1:0]   need_in;
    logic                free_bad;
    logic [WORD_W-1:0]   gsz;
    logic                grow_fail;
    logic [WORD_W-1:0]   rem;
    logic                res_fire;
    logic [WORD_W-1:0]   res_addr;
    logic                res_grant;

    function automatic mem_req_t rd_req(input logic [WORD_W-1:0] addr);
        mem_req_t r;
        r       = '0;
        r.rd    = 1'b1;
        r.addr  = addr;
        return r;
    endfunction

    function automatic mem_req_t wr_req(input logic [WORD_W-1:0] addr,
                                        input logic [WORD_W-1:0] data);
        mem_req_t r;
        r       = '0;
        r.wr    = 1'b1;
        r.addr  = addr;
        r.wdata = data;
        return r;
    endfunction

    assign rv_size = {rv[WORD_W-1:3], 3'b000};
    assign need32  = WORD_W'(need_reg);
    assign need_in = (request_bytes <= REQ_W'(SMALL_REQ)) ? NEED_W'(MIN_BLOCK)
                   : ((NEED_W'(request_bytes) + NEED_W'(15)) & ~NEED_W'(7));
    assign free_bad = (block_address < BADDR_W'(FIRST_BLOCK)) || (block_address[2:0] != 3'b000)
                   || (WORD_W'(block_address) >= brk_reg);
    assign gsz       = (need32 > WORD_W'(CHUNK_BYTES)) ? need32 : WORD_W'(CHUNK_SZ);
    assign grow_fail = (brk_reg > WORD_W'(HEAP_BYTES)) || (gsz > WORD_W'(HEAP_BYTES) - brk_reg);
    assign rem       = rv_size - need32;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:     state_next = mem_ready ? ST_IDLE : ST_CLEAR;
            ST_IDLE:
            begin
                if (start)
                begin
                    if (action == ACT_ALLOC)
                    begin
                        if (request_bytes == '0)
                            state_next = ST_IDLE;
                        else if (rover_reg == '0)
                            state_next = ST_GROW;
                        else
                            state_next = ST_S1;
                    end
                    else
                    begin
                        state_next = free_bad ? ST_IDLE : ST_F1;
                    end
                end
            end
            ST_S1:        state_next = ST_S2;
            ST_S2:        state_next = ST_S3;
            ST_S3:
            begin
                if (need32 <= rv_size)
                    state_next = ST_U0;
                else if (a_reg == stop_reg || cnt_reg == WALK_W'(MAX_WALK - 1))
                    state_next = ST_GROW;
                else
                    state_next = ST_S2;
            end
            ST_GROW:      state_next = grow_fail ? ST_IDLE : ST_G1;
            ST_G1:        state_next = ST_G2;
            ST_G2:        state_next = ST_G3;
            ST_G3:        state_next = ST_M0;
            ST_GROW_RET:  state_next = (p_reg == '0) ? ST_IDLE : ST_U0;
            ST_C1:        state_next = ST_C2;
            ST_C2:        state_next = ST_K0;
            ST_K0:        state_next = ST_K1;
            ST_K1:        state_next = ST_K2;
            ST_K2:        state_next = nosplit_reg ? ST_FIN0 : ST_K3;
            ST_K3:        state_next = ST_K4;
            ST_K4:        state_next = ST_K5;
            ST_K5:        state_next = ST_K6;
            ST_K6:        state_next = ST_L0;
            ST_FIN0:      state_next = ST_FIN1;
            ST_FIN1:      state_next = ST_IDLE;
            ST_F1:        state_next = rv[0] ? ST_F2 : ST_IDLE;
            ST_F2:        state_next = ST_F3;
            ST_F3:        state_next = ST_M0;
            ST_FREE_DONE: state_next = ST_IDLE;
            ST_M0:        state_next = ST_M1;
            ST_M1:        state_next = ST_M2;
            ST_M2:        state_next = ST_M3;
            ST_M3:        state_next = ST_M4;
            ST_M4:        state_next = ST_M5;
            ST_M5:
            begin
                priority if (prev_used_reg && rv[0])
                    state_next = ST_L0;
                else if (prev_used_reg)
                    state_next = ST_U0;
                else if (rv[0])
                    state_next = ST_M30;
                else
                    state_next = ST_U0;
            end
            ST_M20:       state_next = ST_M21;
            ST_M21:       state_next = ST_M22;
            ST_M22:       state_next = ST_M23;
            ST_M23:       state_next = ST_M24;
            ST_M24:       state_next = ST_CHK0;
            ST_M30:       state_next = ST_U0;
            ST_M31:       state_next = ST_M32;
            ST_M32:       state_next = ST_M33;
            ST_M33:       state_next = ST_M34;
            ST_M34:       state_next = ST_M35;
            ST_M35:       state_next = ST_M36;
            ST_M36:       state_next = ST_M37;
            ST_M37:       state_next = ST_M38;
            ST_M38:       state_next = ST_CHK1;
            ST_M40:       state_next = ST_M41;
            ST_M41:       state_next = ST_U0;
            ST_M42:       state_next = ST_M43;
            ST_M43:       state_next = ST_M44;
            ST_M44:       state_next = ST_M45;
            ST_M45:       state_next = ST_M46;
            ST_M46:       state_next = ST_M47;
            ST_M47:       state_next = ST_M48;
            ST_M48:       state_next = ST_M49;
            ST_M49:       state_next = ST_M4A;
            ST_M4A:       state_next = ST_M4B;
            ST_M4B:       state_next = ST_M4C;
            ST_M4C:       state_next = ST_M4D;
            ST_M4D:       state_next = ST_CHK1;
            ST_CHK0:      state_next = ST_CHK1;
            ST_CHK1:      state_next = ST_L0;
            ST_MRET:      state_next = merge_ret_reg;
            ST_U0:        state_next = ST_U1;
            ST_U1:        state_next = ST_U2;
            ST_U2:
            begin
                if (x_reg == head_reg && succ_reg == x_reg)
                    state_next = sub_ret_reg;
                else
                    state_next = ST_U3;
            end
            ST_U3:        state_next = ST_U4;
            ST_U4:        state_next = sub_ret_reg;
            ST_L0:        state_next = (head_reg == '0) ? ST_L1 : ST_L2;
            ST_L1:        state_next = sub_ret_reg;
            ST_L2:        state_next = ST_L3;
            ST_L3:        state_next = ST_L4;
            ST_L4:        state_next = ST_L5;
            ST_L5:        state_next = ST_L6;
            ST_L6:        state_next = ST_L7;
            ST_L7:        state_next = sub_ret_reg;
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath, memory requests and results
    always_comb
    begin
        mreq           = '0;
        sub_ret_next   = sub_ret_reg;
        merge_ret_next = merge_ret_reg;
        brk_next       = brk_reg;
        head_next      = head_reg;
        rover_next     = rover_reg;
        p_next         = p_reg;
        a_next         = a_reg;
        x_next         = x_reg;
        sz_next        = sz_reg;
        stop_next      = stop_reg;
        succ_next      = succ_reg;
        pred_next      = pred_reg;
        v1_next        = v1_reg;
        v2_next        = v2_reg;
        need_next      = need_reg;
        cnt_next       = cnt_reg;
        prev_used_next = prev_used_reg;
        nosplit_next   = nosplit_reg;
        hi_next        = hi_reg;
        res_fire       = 1'b0;
        res_addr       = '0;
        res_grant      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (action == ACT_ALLOC)
                    begin
                        need_next = need_in;
                        if (request_bytes == '0)
                            res_fire = 1'b1;
                        else if (rover_reg != '0)
                            mreq = rd_req(rover_reg);
                    end
                    else if (free_bad)
                    begin
                        res_fire = 1'b1;
                    end
                    else
                    begin
                        p_next = WORD_W'(block_address);
                        mreq   = rd_req(WORD_W'(block_address) - 32'd4);
                    end
                end
            end
            // next-fit walk
            ST_S1:
            begin
                stop_next = rv;
                a_next    = rv;
                cnt_next  = '0;
                mreq      = rd_req(rv + 32'd4);
            end
            ST_S2:
            begin
                a_next = rv;
                mreq   = rd_req(rv - 32'd4);
            end
            ST_S3:
            begin
                if (need32 <= rv_size)
                begin
                    rover_next   = a_reg;
                    p_next       = a_reg;
                    x_next       = a_reg;
                    sub_ret_next = ST_C1;
                end
                else if (a_reg == stop_reg || cnt_reg == WALK_W'(MAX_WALK - 1))
                begin
                    rover_next = a_reg;
                end
                else
                begin
                    cnt_next = cnt_reg + WALK_W'(1);
                    mreq     = rd_req(a_reg + 32'd4);
                end
            end
            // heap growth
            ST_GROW:
            begin
                if (grow_fail)
                begin
                    res_fire = 1'b1;
                end
                else
                begin
                    p_next   = brk_reg;
                    brk_next = brk_reg + gsz;
                    sz_next  = gsz;
                end
            end
            ST_G1: mreq = wr_req(p_reg - 32'd4, sz_reg);
            ST_G2: mreq = wr_req(p_reg + sz_reg - 32'd8, sz_reg);
            ST_G3:
            begin
                mreq           = wr_req(p_reg + sz_reg - 32'd4, WORD_W'(EPILOGUE_TAG));
                merge_ret_next = ST_GROW_RET;
            end
            ST_GROW_RET:
            begin
                if (p_reg == '0)
                begin
                    res_fire = 1'b1;
                end
                else
                begin
                    x_next       = p_reg;
                    sub_ret_next = ST_C1;
                end
            end
            // split of the chosen block
            ST_C1: mreq = rd_req(p_reg - 32'd4);
            ST_C2:
            begin
                if (rem <= WORD_W'(SPLIT_SLACK))
                begin
                    nosplit_next = 1'b1;
                    v1_next      = rv_size | 32'd1;
                end
                else if (need32 >= WORD_W'(thr_reg))
                begin
                    nosplit_next = 1'b0;
                    hi_next      = 1'b1;
                    v1_next      = rem;
                    v2_next      = need32 | 32'd1;
                end
                else
                begin
                    nosplit_next = 1'b0;
                    hi_next      = 1'b0;
                    v1_next      = need32 | 32'd1;
                    v2_next      = rem;
                end
            end
            ST_K0: mreq = wr_req(p_reg - 32'd4, v1_reg);
            ST_K1: mreq = rd_req(p_reg - 32'd4);
            ST_K2: mreq = wr_req(p_reg + rv_size - 32'd8, v1_reg);
            ST_K3: mreq = rd_req(p_reg - 32'd4);
            ST_K4:
            begin
                a_next = p_reg + rv_size;
                mreq   = wr_req(p_reg + rv_size - 32'd4, v2_reg);
            end
            ST_K5: mreq = rd_req(a_reg - 32'd4);
            ST_K6:
            begin
                mreq         = wr_req(a_reg + rv_size - 32'd8, v2_reg);
                x_next       = hi_reg ? p_reg : a_reg;
                sub_ret_next = ST_FIN0;
            end
            ST_FIN0: mreq = rd_req(p_reg - 32'd4);
            ST_FIN1:
            begin
                res_fire  = 1'b1;
                res_grant = 1'b1;
                res_addr  = rv[0] ? p_reg : p_reg + rv_size;
            end
            // release
            ST_F1:
            begin
                if (!rv[0])
                begin
                    res_fire = 1'b1;
                end
                else
                begin
                    sz_next = rv_size;
                    mreq    = wr_req(p_reg - 32'd4, rv_size);
                end
            end
            ST_F2: mreq = rd_req(p_reg - 32'd4);
            ST_F3:
            begin
                mreq           = wr_req(p_reg + rv_size - 32'd8, sz_reg);
                merge_ret_next = ST_FREE_DONE;
            end
            ST_FREE_DONE:
            begin
                res_fire  = 1'b1;
                res_grant = 1'b1;
            end
            // coalescing
            ST_M0: mreq = rd_req(p_reg - 32'd8);
            ST_M1:
            begin
                a_next = p_reg - rv_size;
                mreq   = rd_req(p_reg - rv_size - 32'd4);
            end
            ST_M2: mreq = rd_req(a_reg + rv_size - 32'd8);
            ST_M3:
            begin
                prev_used_next = rv[0];
                mreq           = rd_req(p_reg - 32'd4);
            end
            ST_M4:
            begin
                sz_next = rv_size;
                a_next  = p_reg + rv_size;
                mreq    = rd_req(p_reg + rv_size - 32'd4);
            end
            ST_M5:
            begin
                priority if (prev_used_reg && rv[0])
                begin
                    x_next       = p_reg;
                    sub_ret_next = ST_MRET;
                end
                else if (prev_used_reg)
                begin
                    x_next       = a_reg;
                    sub_ret_next = ST_M20;
                end
                else if (rv[0])
                begin
                    mreq = rd_req(p_reg - 32'd8);
                end
                else
                begin
                    x_next       = a_reg;
                    sub_ret_next = ST_M40;
                end
            end
            ST_M20: mreq = rd_req(p_reg - 32'd4);
            ST_M21: mreq = rd_req(p_reg + rv_size - 32'd4);
            ST_M22:
            begin
                sz_next = sz_reg + rv_size;
                mreq    = wr_req(p_reg - 32'd4, sz_reg + rv_size);
            end
            ST_M23: mreq = rd_req(p_reg - 32'd4);
            ST_M24: mreq = wr_req(p_reg + rv_size - 32'd8, sz_reg);
            ST_M30:
            begin
                x_next       = p_reg - rv_size;
                sub_ret_next = ST_M31;
            end
            ST_M31: mreq = rd_req(p_reg - 32'd8);
            ST_M32: mreq = rd_req(p_reg - rv_size - 32'd4);
            ST_M33:
            begin
                sz_next = sz_reg + rv_size;
                mreq    = rd_req(p_reg - 32'd4);
            end
            ST_M34: mreq = wr_req(p_reg + rv_size - 32'd8, sz_reg);
            ST_M35: mreq = rd_req(p_reg - 32'd8);
            ST_M36: mreq = wr_req(p_reg - rv_size - 32'd4, sz_reg);
            ST_M37: mreq = rd_req(p_reg - 32'd8);
            ST_M38:
            begin
                p_next = p_reg - rv_size;
                mreq   = rd_req(p_reg - rv_size - 32'd4);
            end
            ST_M40: mreq = rd_req(p_reg - 32'd8);
            ST_M41:
            begin
                x_next       = p_reg - rv_size;
                sub_ret_next = ST_M42;
            end
            ST_M42: mreq = rd_req(p_reg - 32'd8);
            ST_M43: mreq = rd_req(p_reg - rv_size - 32'd4);
            ST_M44:
            begin
                sz_next = sz_reg + rv_size;
                mreq    = rd_req(p_reg - 32'd4);
            end
            ST_M45:
            begin
                a_next = p_reg + rv_size;
                mreq   = rd_req(p_reg + rv_size - 32'd4);
            end
            ST_M46: mreq = rd_req(a_reg + rv_size - 32'd8);
            ST_M47:
            begin
                sz_next = sz_reg + rv_size;
                mreq    = rd_req(p_reg - 32'd8);
            end
            ST_M48: mreq = wr_req(p_reg - rv_size - 32'd4, sz_reg);
            ST_M49: mreq = rd_req(p_reg - 32'd4);
            ST_M4A:
            begin
                a_next = p_reg + rv_size;
                mreq   = rd_req(p_reg + rv_size - 32'd4);
            end
            ST_M4B: mreq = wr_req(a_reg + rv_size - 32'd8, sz_reg);
            ST_M4C: mreq = rd_req(p_reg - 32'd8);
            ST_M4D:
            begin
                p_next = p_reg - rv_size;
                mreq   = rd_req(p_reg - rv_size - 32'd4);
            end
            ST_CHK0: mreq = rd_req(p_reg - 32'd4);
            ST_CHK1:
            begin
                if (rover_reg > p_reg && rover_reg < p_reg + rv_size)
                    rover_next = p_reg;
                x_next       = p_reg;
                sub_ret_next = ST_MRET;
            end
            // unlink from the free list
            ST_U0: mreq = rd_req(x_reg + 32'd4);
            ST_U1:
            begin
                succ_next = rv;
                mreq      = rd_req(x_reg);
            end
            ST_U2:
            begin
                pred_next = rv;
                if (x_reg == head_reg && succ_reg == x_reg)
                begin
                    head_next  = '0;
                    rover_next = '0;
                end
                else
                begin
                    if (x_reg == head_reg)
                        head_next = succ_reg;
                    if (rover_reg == x_reg)
                        rover_next = succ_reg;
                end
            end
            ST_U3: mreq = wr_req(pred_reg + 32'd4, succ_reg);
            ST_U4: mreq = wr_req(succ_reg, pred_reg);
            // push at the list head
            ST_L0:
            begin
                if (head_reg == '0)
                    mreq = wr_req(x_reg, x_reg);
                else
                    mreq = wr_req(x_reg + 32'd4, head_reg);
            end
            ST_L1:
            begin
                mreq       = wr_req(x_reg + 32'd4, x_reg);
                head_next  = x_reg;
                rover_next = x_reg;
            end
            ST_L2: mreq = rd_req(head_reg);
            ST_L3: mreq = wr_req(x_reg, rv);
            ST_L4: mreq = rd_req(x_reg + 32'd4);
            ST_L5: mreq = wr_req(rv, x_reg);
            ST_L6: mreq = rd_req(x_reg);
            ST_L7:
            begin
                mreq      = wr_req(rv + 32'd4, x_reg);
                head_next = x_reg;
            end
            default:
            begin
                mreq = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            brk_reg     <= WORD_W'(INIT_BRK);
            head_reg    <= WORD_W'(FIRST_BLOCK);
            rover_reg   <= WORD_W'(FIRST_BLOCK);
            thr_reg     <= THR_W'(THR_RESET);
            done_reg    <= 1'b0;
            paddr_reg   <= '0;
            granted_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            brk_reg     <= brk_next;
            head_reg    <= head_next;
            rover_reg   <= rover_next;
            done_reg    <= res_fire;
            paddr_reg   <= res_addr[BADDR_W-1:0];
            granted_reg <= res_grant;
            if (cfg_write)
            begin
                thr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sub_ret_reg   <= sub_ret_next;
        merge_ret_reg <= merge_ret_next;
        p_reg         <= p_next;
        a_reg         <= a_next;
        x_reg         <= x_next;
        sz_reg        <= sz_next;
        stop_reg      <= stop_next;
        succ_reg      <= succ_next;
        pred_reg      <= pred_next;
        v1_reg        <= v1_next;
        v2_reg        <= v2_next;
        need_reg      <= need_next;
        cnt_reg       <= cnt_next;
        prev_used_reg <= prev_used_next;
        nosplit_reg   <= nosplit_next;
        hi_reg        <= hi_next;
    end

    efla_mem #(
        .HEAP_BYTES  (HEAP_BYTES),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rdata (rv),
        .ready (mem_ready)
    );

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign payload_address = paddr_reg;
    assign granted         = granted_reg;

endmodule

/* src/efla_ram.sv */
module efla_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 262144
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/efla_mem.sv */
module efla_mem
    import efla_pkg::*;
#(
    parameter int HEAP_BYTES  = 1048576,
    parameter int CHUNK_BYTES = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mem_req_t          req,
    output logic [WORD_W-1:0] rdata,
    output logic              ready
);

    localparam int STORE_WORDS = HEAP_BYTES / 4;
    localparam int WORD_AW     = $clog2(STORE_WORDS);
    localparam int CHUNK_SZ    = ((CHUNK_BYTES / 4 + 1) / 2) * 8;
    localparam bit INIT_FITS   = (CHUNK_SZ <= HEAP_BYTES - 32);
    localparam int INIT_TOTAL  = INIT_FITS ? FIRST_BLOCK + CHUNK_SZ : FIRST_BLOCK;
    localparam int GROW_FOOT   = 32 + CHUNK_SZ - 8;
    localparam int GROW_EPI    = 32 + CHUNK_SZ - 4;

    logic               clearing_reg;
    logic [WORD_AW-1:0] clr_reg;
    logic [WORD_AW-1:0] clr_next;
    logic               oor_reg;
    logic               in_range;
    logic [WORD_W-1:0]  init_byte;
    logic [WORD_W-1:0]  init_word;
    logic               ram_we;
    logic [WORD_AW-1:0] ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [WORD_W-1:0]  ram_q;

    assign in_range = req.addr[WORD_W-1:2] < (WORD_W-2)'(STORE_WORDS);
    assign clr_next = clr_reg + WORD_AW'(1);

    // reset image of the heap
    always_comb
    begin
        init_byte = WORD_W'(clr_reg) << 2;
        priority if (init_byte == 32'd4 || init_byte == 32'd8)
            init_word = WORD_W'(PROLOGUE_TAG);
        else if (init_byte == 32'd12)
            init_word = WORD_W'(INIT_TOTAL);
        else if (init_byte == 32'd16 || init_byte == 32'd20 || init_byte == 32'd24)
            init_word = WORD_W'(FIRST_BLOCK);
        else if (init_byte == 32'd28)
            init_word = INIT_FITS ? WORD_W'(CHUNK_SZ) : WORD_W'(EPILOGUE_TAG);
        else if (INIT_FITS && init_byte == WORD_W'(GROW_FOOT))
            init_word = WORD_W'(INIT_TOTAL);
        else if (INIT_FITS && init_byte == WORD_W'(GROW_EPI))
            init_word = WORD_W'(EPILOGUE_TAG);
        else
            init_word = '0;
    end

    always_comb
    begin
        if (clearing_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = init_word;
        end
        else
        begin
            ram_we    = req.wr && in_range;
            ram_waddr = req.addr[WORD_AW+1:2];
            ram_wdata = req.wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_reg      <= '0;
        end
        else if (clearing_reg)
        begin
            clr_reg <= clr_next;
            if (clr_reg == WORD_AW'(STORE_WORDS - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        oor_reg <= !in_range;
    end

    efla_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (req.addr[WORD_AW+1:2]),
        .rdata (ram_q)
    );

    assign rdata = oor_reg ? '0 : ram_q;
    assign ready = !clearing_reg;

endmodule

/* src/efla_chk.sv */
module efla_chk
    import efla_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic [BADDR_W-1:0] payload_address,
    input logic               granted
);

    // nothing shows between results
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> !granted && payload_address == '0)
        else $error("result ports active without strobe");

    // a refused request carries a null address
    a_null: assert property (@(posedge clk) disable iff (!rst_n)
        done && !granted |-> payload_address == '0)
        else $error("refused request with address");

    // a result follows either a request taken from idle or the end of work
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy) || $past(start))
        else $error("result without request");

    // a result ends the busy period it belongs to
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(busy) |-> !busy || $past(start))
        else $error("result while still busy");

endmodule

bind explicit_free_list_heap_allocator efla_chk u_efla_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .payload_address (payload_address),
    .granted         (granted)
);
